FILE: design/fuvt_pkg.sv
package fuvt_pkg;

    localparam int IN_W  = 16;
    localparam int OUT_W = 16;
    localparam int CNT_W = 2;

    localparam logic [CNT_W-1:0] CNT_ZERO  = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE   = 2'd1;
    localparam logic [CNT_W-1:0] CNT_MULTI = 2'd2;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic cnt_update;
        logic q_read;
        logic c_read;
        logic pop;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic fill_zero;
        logic head_multi;
    } sts_t;

endpackage

FILE: design/first_unique_value_tracker_unit.sv
// First unique value tracker.
// Input channel (in_valid / in_stall / value) adds one value to the stream; the
// low VALUE_BITS bits form the key. Output channel (out_valid / out_stall) returns
// one result per input transfer: first_unique (oldest value seen exactly once,
// zero when none), found, and the sticky overflow flag.
// After reset the block sweeps the occurrence count memory, one entry per cycle,
// clearing all 2^VALUE_BITS entries with in_stall high; then it takes items.
// One item at a time: after the input transfer the block steps through COUNT and
// QREAD, then, unless the queue ends up empty, through QDATA and CCHECK, back to
// QREAD for each stale entry popped from the queue head. DONE loads the result
// and returns to IDLE for the next transfer. Each pop pays back one earlier push.
// The cost is set by the serial read chain: count memory, queue memory, then
// count memory again for the head entry.
// The result sits in an output register; a stalled receiver holds it there, and
// the block keeps taking and working the next item meanwhile, waiting only to
// load its own result until the register is freed.
// A push into a full queue (QUEUE_DEPTH entries) is dropped and sets overflow.
module first_unique_value_tracker_unit
#(
    parameter int VALUE_BITS  = 16,
    parameter int QUEUE_DEPTH = 1024
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [fuvt_pkg::IN_W-1:0]   value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [fuvt_pkg::OUT_W-1:0]  first_unique,
    output logic                        found,
    output logic                        overflow
);

    fuvt_pkg::cmd_t cmd;
    fuvt_pkg::sts_t sts;

    fuvt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    fuvt_dp
    #(
        .VALUE_BITS  (VALUE_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .first_unique (first_unique),
        .found        (found),
        .overflow     (overflow),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

FILE: design/fuvt_ctrl.sv
module fuvt_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output fuvt_pkg::cmd_t   cmd,
    input  fuvt_pkg::sts_t   sts
);

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        COUNT,
        QREAD,
        QDATA,
        CCHECK,
        DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = IDLE;
                end
            end
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = COUNT;
                end
            end
            COUNT:
            begin
                cmd.cnt_update = 1'b1;
                state_next     = QREAD;
            end
            QREAD:
            begin
                if (sts.fill_zero)
                begin
                    state_next = DONE;
                end
                else
                begin
                    cmd.q_read = 1'b1;
                    state_next = QDATA;
                end
            end
            QDATA:
            begin
                cmd.c_read = 1'b1;
                state_next = CCHECK;
            end
            CCHECK:
            begin
                if (sts.head_multi)
                begin
                    cmd.pop    = 1'b1;
                    state_next = QREAD;
                end
                else
                begin
                    state_next = DONE;
                end
            end
            DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: design/fuvt_dp.sv
module fuvt_dp
#(
    parameter int VALUE_BITS  = 16,
    parameter int QUEUE_DEPTH = 1024
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [fuvt_pkg::IN_W-1:0]   value,
    output logic [fuvt_pkg::OUT_W-1:0]  first_unique,
    output logic                        found,
    output logic                        overflow,
    input  fuvt_pkg::cmd_t              cmd,
    output fuvt_pkg::sts_t              sts
);

    localparam int KEY_COUNT = 1 << VALUE_BITS;
    localparam int QAW       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_COPY   = (VALUE_BITS < fuvt_pkg::IN_W) ? VALUE_BITS : fuvt_pkg::IN_W;
    localparam int OUT_COPY  = (VALUE_BITS < fuvt_pkg::OUT_W) ? VALUE_BITS : fuvt_pkg::OUT_W;

    logic [fuvt_pkg::CNT_W-1:0] cnt_mem [KEY_COUNT];
    logic [VALUE_BITS-1:0]      q_mem   [QUEUE_DEPTH];

    logic [VALUE_BITS-1:0]      key_reg;
    logic [fuvt_pkg::CNT_W-1:0] cnt_rd_reg;
    logic [VALUE_BITS-1:0]      q_rd_reg;
    logic [QAW-1:0]             head_reg;
    logic [QAW-1:0]             head_next;
    logic [QAW-1:0]             tail_reg;
    logic [QAW-1:0]             tail_next;
    logic [FILL_W-1:0]          fill_reg;
    logic [VALUE_BITS-1:0]      clr_addr_reg;
    logic                       overflow_reg;
    logic [fuvt_pkg::OUT_W-1:0] first_reg;
    logic                       found_reg;
    logic                       ovf_out_reg;

    logic [VALUE_BITS-1:0]      in_key;
    logic [fuvt_pkg::OUT_W-1:0] head_ext;
    logic                       full;
    logic                       fill_zero;
    logic                       push_en;
    logic                       cnt_we;
    logic [VALUE_BITS-1:0]      cnt_waddr;
    logic [fuvt_pkg::CNT_W-1:0] cnt_wdata;
    logic [VALUE_BITS-1:0]      cnt_raddr;

    always_comb
    begin
        in_key                = '0;
        in_key[IN_COPY-1:0]   = value[IN_COPY-1:0];
        head_ext              = '0;
        head_ext[OUT_COPY-1:0] = q_rd_reg[OUT_COPY-1:0];
    end

    assign full      = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign fill_zero = (fill_reg == '0);
    assign push_en   = cmd.cnt_update && (cnt_rd_reg == fuvt_pkg::CNT_ZERO) && !full;
    assign head_next = (head_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_next = (tail_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    always_comb
    begin
        cnt_we    = cmd.clr_step || cmd.cnt_update;
        cnt_waddr = cmd.clr_step ? clr_addr_reg : key_reg;
        if (cmd.clr_step)
        begin
            cnt_wdata = fuvt_pkg::CNT_ZERO;
        end
        else if (cnt_rd_reg == fuvt_pkg::CNT_ZERO)
        begin
            cnt_wdata = fuvt_pkg::CNT_ONE;
        end
        else
        begin
            cnt_wdata = fuvt_pkg::CNT_MULTI;
        end
        cnt_raddr = cmd.accept ? in_key : q_rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cmd.accept || cmd.c_read)
        begin
            cnt_rd_reg <= cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            q_mem[tail_reg] <= key_reg;
        end
        if (cmd.q_read)
        begin
            q_rd_reg <= q_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg <= in_key;
        end
        if (cmd.load_out)
        begin
            first_reg   <= fill_zero ? '0 : head_ext;
            found_reg   <= !fill_zero;
            ovf_out_reg <= overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            clr_addr_reg <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (push_en)
            begin
                tail_reg <= tail_next;
                fill_reg <= fill_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                head_reg <= head_next;
                fill_reg <= fill_reg - 1'b1;
            end
            if (cmd.cnt_update && (cnt_rd_reg == fuvt_pkg::CNT_ZERO) && full)
            begin
                overflow_reg <= 1'b1;
            end
        end
    end

    assign sts.clr_done   = &clr_addr_reg;
    assign sts.fill_zero  = fill_zero;
    assign sts.head_multi = (cnt_rd_reg != fuvt_pkg::CNT_ZERO)
                         && (cnt_rd_reg != fuvt_pkg::CNT_ONE);

    assign first_unique = first_reg;
    assign found        = found_reg;
    assign overflow     = ovf_out_reg;

endmodule

FILE: design/fuvt_checker.sv
module fuvt_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [fuvt_pkg::OUT_W-1:0]  first_unique,
    input  logic                        found,
    input  logic                        overflow
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(first_unique) && $stable(found) && $stable(overflow)))
        else $error("stalled result changed");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (first_unique == '0))
        else $error("first_unique nonzero without found");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |=> overflow)
        else $error("overflow flag dropped");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item taken while busy");

endmodule

bind first_unique_value_tracker_unit fuvt_checker u_fuvt_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .first_unique (first_unique),
    .found        (found),
    .overflow     (overflow)
);
